/* rtl/core/quaternion_to_rotation_matrix_assert.svh */
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define Q2R_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define Q2R_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/q2r_pkg.sv */
package q2r_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam int PROD_W    = 2 * COMP_WIDTH - 1;
  localparam int NUM_W     = 2 * COMP_WIDTH;
  localparam int NORM_W    = 2 * COMP_WIDTH + 1;
  localparam int DIV_STEPS = FRAC_BITS + 2;
  localparam int QUO_W     = FRAC_BITS + 2;
  localparam int TERM_W    = FRAC_BITS + 3;
  localparam int SUM_W     = FRAC_BITS + 4;
  localparam int EXT_W     = ((SUM_W > COMP_WIDTH) ? SUM_W : COMP_WIDTH) + 1;
  localparam int STAGES    = DIV_STEPS + 4;

  localparam int LANES = 9;
  localparam int LN_XX = 0;
  localparam int LN_YY = 1;
  localparam int LN_ZZ = 2;
  localparam int LN_XY = 3;
  localparam int LN_XZ = 4;
  localparam int LN_YZ = 5;
  localparam int LN_WX = 6;
  localparam int LN_WY = 7;
  localparam int LN_WZ = 8;

  localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) <<< FRAC_BITS;

  function automatic logic [COMP_WIDTH-1:0] saturate(input logic signed [SUM_W-1:0] v);
    logic signed [EXT_W-1:0] e;
    logic signed [EXT_W-1:0] one;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    e = {{(EXT_W - SUM_W){v[SUM_W-1]}}, v};
    one = '0;
    one[FRAC_BITS] = 1'b1;
    hi = '0;
    hi[COMP_WIDTH-2:0] = '1;
    lo = ~hi;
    if (e > one) e = one;
    if (e < -one) e = -one;
    if (e > hi) e = hi;
    if (e < lo) e = lo;
    return e[COMP_WIDTH-1:0];
  endfunction

endpackage

/* rtl/core/quaternion_to_rotation_matrix.sv */
// Channel  Direction  Handshake              Words
// quat     in         quat_valid/quat_stall  quat_w, quat_x, quat_y, quat_z
// mat      out        mat_valid/mat_stall    row0_col0 .. row2_col2
//
// One word enters per cycle while quat_stall is low; matrix entries are Q1.14,
// and the restoring divider spends one stage on each quotient bit.
// rst clears all valid bits; the datapath registers are not reset.
// A stall on mat holds only the full stages in front of the output; empty
// stages still advance, so quat_stall rises only when every stage is full.
module quaternion_to_rotation_matrix import q2r_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         quat_valid,
  output logic                         quat_stall,
  input  logic signed [COMP_WIDTH-1:0] quat_w,
  input  logic signed [COMP_WIDTH-1:0] quat_x,
  input  logic signed [COMP_WIDTH-1:0] quat_y,
  input  logic signed [COMP_WIDTH-1:0] quat_z,
  output logic                         mat_valid,
  input  logic                         mat_stall,
  output logic signed [COMP_WIDTH-1:0] row0_col0,
  output logic signed [COMP_WIDTH-1:0] row0_col1,
  output logic signed [COMP_WIDTH-1:0] row0_col2,
  output logic signed [COMP_WIDTH-1:0] row1_col0,
  output logic signed [COMP_WIDTH-1:0] row1_col1,
  output logic signed [COMP_WIDTH-1:0] row1_col2,
  output logic signed [COMP_WIDTH-1:0] row2_col0,
  output logic signed [COMP_WIDTH-1:0] row2_col1,
  output logic signed [COMP_WIDTH-1:0] row2_col2
);

  function automatic logic [COMP_WIDTH-1:0] mag(input logic signed [COMP_WIDTH-1:0] a);
    logic [COMP_WIDTH-1:0] u;
    u = a;
    return u[COMP_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic signed [TERM_W-1:0] t);
    return {t[TERM_W-1], t};
  endfunction

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  logic [COMP_WIDTH-1:0] mw, mx, my, mz;
  logic [COMP_WIDTH-1:0] pa [LANES];
  logic [COMP_WIDTH-1:0] pb [LANES];
  logic [LANES-1:0]      sg;
  logic [NUM_W-1:0]      pr [LANES];
  logic [NUM_W-1:0]      pr_ww;

  logic [PROD_W-1:0] p_prod [LANES];
  logic [PROD_W-1:0] p_ww;
  logic [LANES-1:0]  p_neg;

  logic [NORM_W-1:0] n_norm;
  logic [NUM_W-1:0]  n_num [LANES];
  logic [LANES-1:0]  n_neg;
  logic              n_nz;

  logic [NORM_W-1:0]    d_rem      [DIV_STEPS][LANES];
  logic [QUO_W-1:0]     d_quo      [DIV_STEPS][LANES];
  logic [NORM_W-1:0]    d_den      [DIV_STEPS];
  logic [LANES-1:0]     d_neg      [DIV_STEPS];
  logic [DIV_STEPS-1:0] d_nz;
  logic [NORM_W-1:0]    d_rem_next [DIV_STEPS][LANES];
  logic [QUO_W-1:0]     d_quo_next [DIV_STEPS][LANES];

  logic [TERM_W-1:0]        rq      [LANES];
  logic signed [TERM_W-1:0] rt_next [LANES];
  logic signed [TERM_W-1:0] r_term  [LANES];

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      en[k] = !mat_stall || (|(~v >> k));
    end
  end

  assign quat_stall = !en[0];
  assign mat_valid  = v[STAGES-1];

  always_comb begin
    mw = mag(quat_w);
    mx = mag(quat_x);
    my = mag(quat_y);
    mz = mag(quat_z);
    pa[LN_XX] = mx; pb[LN_XX] = mx; sg[LN_XX] = 1'b0;
    pa[LN_YY] = my; pb[LN_YY] = my; sg[LN_YY] = 1'b0;
    pa[LN_ZZ] = mz; pb[LN_ZZ] = mz; sg[LN_ZZ] = 1'b0;
    pa[LN_XY] = mx; pb[LN_XY] = my; sg[LN_XY] = quat_x[COMP_WIDTH-1] ^ quat_y[COMP_WIDTH-1];
    pa[LN_XZ] = mx; pb[LN_XZ] = mz; sg[LN_XZ] = quat_x[COMP_WIDTH-1] ^ quat_z[COMP_WIDTH-1];
    pa[LN_YZ] = my; pb[LN_YZ] = mz; sg[LN_YZ] = quat_y[COMP_WIDTH-1] ^ quat_z[COMP_WIDTH-1];
    pa[LN_WX] = mw; pb[LN_WX] = mx; sg[LN_WX] = quat_w[COMP_WIDTH-1] ^ quat_x[COMP_WIDTH-1];
    pa[LN_WY] = mw; pb[LN_WY] = my; sg[LN_WY] = quat_w[COMP_WIDTH-1] ^ quat_y[COMP_WIDTH-1];
    pa[LN_WZ] = mw; pb[LN_WZ] = mz; sg[LN_WZ] = quat_w[COMP_WIDTH-1] ^ quat_z[COMP_WIDTH-1];
    for (int i = 0; i < LANES; i++) begin
      pr[i] = NUM_W'(pa[i]) * NUM_W'(pb[i]);
    end
    pr_ww = NUM_W'(mw) * NUM_W'(mw);
  end

  always_comb begin
    for (int d = 0; d < DIV_STEPS; d++) begin
      for (int i = 0; i < LANES; i++) begin
        logic [NORM_W:0]   r_in;
        logic [NORM_W:0]   r_sub;
        logic [NORM_W-1:0] den;
        logic [QUO_W-1:0]  q_in;
        logic              ge;
        if (d == 0) begin
          r_in = {2'b00, n_num[i]};
          den  = n_norm;
          q_in = '0;
        end else begin
          r_in = {d_rem[d-1][i], 1'b0};
          den  = d_den[d-1];
          q_in = d_quo[d-1][i];
        end
        ge = r_in >= {1'b0, den};
        r_sub = ge ? (r_in - {1'b0, den}) : r_in;
        d_rem_next[d][i] = r_sub[NORM_W-1:0];
        d_quo_next[d][i] = {q_in[QUO_W-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rq[i] = TERM_W'(d_quo[DIV_STEPS-1][i] >> 1) + TERM_W'(d_quo[DIV_STEPS-1][i][0]);
      if (!d_nz[DIV_STEPS-1]) begin
        rt_next[i] = '0;
      end else if (d_neg[DIV_STEPS-1][i]) begin
        rt_next[i] = ~rq[i] + 1'b1;
      end else begin
        rt_next[i] = rq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= quat_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        p_prod[i] <= pr[i][PROD_W-1:0];
      end
      p_ww  <= pr_ww[PROD_W-1:0];
      p_neg <= sg;
    end
    if (en[1]) begin
      n_norm <= NORM_W'(p_ww) + NORM_W'(p_prod[LN_XX]) + NORM_W'(p_prod[LN_YY])
              + NORM_W'(p_prod[LN_ZZ]);
      for (int i = 0; i < LANES; i++) begin
        n_num[i] <= {p_prod[i], 1'b0};
      end
      n_neg <= p_neg;
      n_nz  <= |{p_ww, p_prod[LN_XX], p_prod[LN_YY], p_prod[LN_ZZ]};
    end
    for (int d = 0; d < DIV_STEPS; d++) begin
      if (en[d+2]) begin
        for (int i = 0; i < LANES; i++) begin
          d_rem[d][i] <= d_rem_next[d][i];
          d_quo[d][i] <= d_quo_next[d][i];
        end
        if (d == 0) begin
          d_den[d] <= n_norm;
          d_neg[d] <= n_neg;
          d_nz[d]  <= n_nz;
        end else begin
          d_den[d] <= d_den[d-1];
          d_neg[d] <= d_neg[d-1];
          d_nz[d]  <= d_nz[d-1];
        end
      end
    end
    if (en[STAGES-2]) begin
      for (int i = 0; i < LANES; i++) begin
        r_term[i] <= rt_next[i];
      end
    end
    if (en[STAGES-1]) begin
      row0_col0 <= saturate(ONE_SUM - (ext(r_term[LN_YY]) + ext(r_term[LN_ZZ])));
      row0_col1 <= saturate(ext(r_term[LN_XY]) + ext(r_term[LN_WZ]));
      row0_col2 <= saturate(ext(r_term[LN_XZ]) - ext(r_term[LN_WY]));
      row1_col0 <= saturate(ext(r_term[LN_XY]) - ext(r_term[LN_WZ]));
      row1_col1 <= saturate(ONE_SUM - (ext(r_term[LN_XX]) + ext(r_term[LN_ZZ])));
      row1_col2 <= saturate(ext(r_term[LN_YZ]) + ext(r_term[LN_WX]));
      row2_col0 <= saturate(ext(r_term[LN_XZ]) + ext(r_term[LN_WY]));
      row2_col1 <= saturate(ext(r_term[LN_YZ]) - ext(r_term[LN_WX]));
      row2_col2 <= saturate(ONE_SUM - (ext(r_term[LN_XX]) + ext(r_term[LN_YY])));
    end
  end

endmodule

/* rtl/core/q2r_checker.sv */
`include "quaternion_to_rotation_matrix_assert.svh"

module q2r_checker import q2r_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         quat_stall,
  input logic                         mat_valid,
  input logic                         mat_stall,
  input logic signed [COMP_WIDTH-1:0] row0_col0,
  input logic signed [COMP_WIDTH-1:0] row0_col1,
  input logic signed [COMP_WIDTH-1:0] row0_col2,
  input logic signed [COMP_WIDTH-1:0] row1_col0,
  input logic signed [COMP_WIDTH-1:0] row1_col1,
  input logic signed [COMP_WIDTH-1:0] row1_col2,
  input logic signed [COMP_WIDTH-1:0] row2_col0,
  input logic signed [COMP_WIDTH-1:0] row2_col1,
  input logic signed [COMP_WIDTH-1:0] row2_col2
);

  localparam logic signed [COMP_WIDTH:0] ONE_CHK = (COMP_WIDTH + 1)'(1) <<< FRAC_BITS;

  logic [9*COMP_WIDTH-1:0] mat_word;
  logic                    diag_ok;

  assign mat_word = {row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
                     row2_col0, row2_col1, row2_col2};
  assign diag_ok  = (row0_col0 <= ONE_CHK) && (row0_col0 >= -ONE_CHK)
                 && (row1_col1 <= ONE_CHK) && (row1_col1 >= -ONE_CHK)
                 && (row2_col2 <= ONE_CHK) && (row2_col2 >= -ONE_CHK);

  `Q2R_ASSERT_NXT(a_mat_hold, mat_valid && mat_stall, mat_valid, "mat word dropped while stalled")

  `Q2R_ASSERT_NXT(a_mat_stable, mat_valid && mat_stall, $stable(mat_word), "mat word changed")

  `Q2R_ASSERT_IMP(a_bubble_accepts, !mat_valid, !quat_stall, "quat stalled with empty output")

  `Q2R_ASSERT_IMP(a_stall_source, quat_stall, mat_stall, "quat stalled without a stall on mat")

  `Q2R_ASSERT_IMP(a_diag_range, mat_valid, diag_ok, "diagonal entry beyond one")

endmodule

bind quaternion_to_rotation_matrix q2r_checker u_q2r_checker (.*);

/* tb/quaternion_to_rotation_matrix_tb.sv */
`timescale 1ns / 100ps

module quaternion_to_rotation_matrix_tb;
  import q2r_pkg::*;

  typedef logic [3:0][COMP_WIDTH-1:0] quat_t;
  typedef logic [8:0][COMP_WIDTH-1:0] mat_t;
  typedef struct packed {
    quat_t q;
    logic  typed;
    mat_t  m;
  } stim_row_t;

  localparam logic [COMP_WIDTH-1:0] ZERO    = 16'h0000;
  localparam logic [COMP_WIDTH-1:0] ONE     = 16'h4000;
  localparam logic [COMP_WIDTH-1:0] NEG_ONE = 16'hC000;
  localparam logic [COMP_WIDTH-1:0] MAX_POS = 16'h7FFF;
  localparam logic [COMP_WIDTH-1:0] MAX_NEG = 16'h8000;
  localparam mat_t IDENTITY = {ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE};
  localparam mat_t AXIS_X   = {ONE, ZERO, ZERO, ZERO, NEG_ONE, ZERO, ZERO, ZERO, NEG_ONE};
  localparam mat_t AXIS_Y   = {NEG_ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, NEG_ONE};
  localparam mat_t AXIS_Z   = {NEG_ONE, ZERO, ZERO, ZERO, NEG_ONE, ZERO, ZERO, ZERO, ONE};
  localparam mat_t CYCLE    = {ZERO, ONE, ZERO, ZERO, ZERO, ONE, ONE, ZERO, ZERO};
  localparam mat_t NO_MAT   = '0;

  localparam int DIRECTED_ROWS    = 21;
  localparam int RANDOM_PER_PHASE = 330;
  localparam int HOLD_CYCLES      = 80;
  localparam int DRAIN_CYCLES     = 30;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         quat_valid = 1'b0;
  logic                         quat_stall;
  logic signed [COMP_WIDTH-1:0] quat_w = '0;
  logic signed [COMP_WIDTH-1:0] quat_x = '0;
  logic signed [COMP_WIDTH-1:0] quat_y = '0;
  logic signed [COMP_WIDTH-1:0] quat_z = '0;
  logic                         mat_valid;
  logic                         mat_stall = 1'b0;
  logic signed [COMP_WIDTH-1:0] row0_col0, row0_col1, row0_col2;
  logic signed [COMP_WIDTH-1:0] row1_col0, row1_col1, row1_col2;
  logic signed [COMP_WIDTH-1:0] row2_col0, row2_col1, row2_col2;

  mat_t      expected_mats[$];
  stim_row_t directed_rows[DIRECTED_ROWS];
  string     entry_names[9] = '{"row0_col0", "row0_col1", "row0_col2",
                                "row1_col0", "row1_col1", "row1_col2",
                                "row2_col0", "row2_col1", "row2_col2"};

  int   phase = 0;
  int   send_idle_pct = 31;
  int   recv_idle_pct = 78;
  logic long_hold = 1'b0;
  int   mismatches = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   input_stall_cycles = 0;

  quaternion_to_rotation_matrix uut (
    .clk        (clk),
    .rst        (rst),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .quat_w     (quat_w),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .mat_valid  (mat_valid),
    .mat_stall  (mat_stall),
    .row0_col0  (row0_col0),
    .row0_col1  (row0_col1),
    .row0_col2  (row0_col2),
    .row1_col0  (row1_col0),
    .row1_col1  (row1_col1),
    .row1_col2  (row1_col2),
    .row2_col0  (row2_col0),
    .row2_col1  (row2_col1),
    .row2_col2  (row2_col2)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint scaled_product(longint a, longint b, longint norm);
    longint unsigned num;
    longint unsigned quo;
    num = 2 * ((a < 0 ? -a : a) * (b < 0 ? -b : b));
    quo = (num << (FRAC_BITS + 1)) / longint'(norm);
    quo = (quo >> 1) + (quo & 1);
    return ((a < 0) != (b < 0)) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic logic [COMP_WIDTH-1:0] clamp_entry(longint v);
    longint unity;
    longint hi;
    unity = longint'(1) <<< FRAC_BITS;
    hi = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
    if (v > unity) v = unity;
    if (v < -unity) v = -unity;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[COMP_WIDTH-1:0];
  endfunction

  function automatic mat_t rotation_from_quat(quat_t q);
    longint w, x, y, z, norm, unity;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    w = longint'($signed(q[3]));
    x = longint'($signed(q[2]));
    y = longint'($signed(q[1]));
    z = longint'($signed(q[0]));
    unity = longint'(1) <<< FRAC_BITS;
    norm = w * w + x * x + y * y + z * z;
    {xx, yy, zz, xy, xz, yz, wx, wy, wz} = '0;
    if (norm != 0) begin
      xx = scaled_product(x, x, norm);
      yy = scaled_product(y, y, norm);
      zz = scaled_product(z, z, norm);
      xy = scaled_product(x, y, norm);
      xz = scaled_product(x, z, norm);
      yz = scaled_product(y, z, norm);
      wx = scaled_product(w, x, norm);
      wy = scaled_product(w, y, norm);
      wz = scaled_product(w, z, norm);
    end
    return {clamp_entry(unity - (yy + zz)), clamp_entry(xy + wz), clamp_entry(xz - wy),
            clamp_entry(xy - wz), clamp_entry(unity - (xx + zz)), clamp_entry(yz + wx),
            clamp_entry(xz + wy), clamp_entry(yz - wx), clamp_entry(unity - (xx + yy))};
  endfunction

  function automatic quat_t random_quat();
    quat_t q;
    int    kind;
    int    c;
    int    corners[7] = '{-32768, 32767, 0, 16384, -16384, 1, -1};
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: c = $urandom;
        1: c = int'($urandom_range(0, 127)) - 64;
        2: c = ($urandom_range(0, 2) == 0) ? 0 : $urandom;
        default: c = corners[$urandom_range(0, 6)];
      endcase
      q[i] = c[COMP_WIDTH-1:0];
    end
    return q;
  endfunction

  task automatic send_quat(quat_t q, mat_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      quat_valid <= 1'b0;
      @(posedge clk);
    end
    quat_valid <= 1'b1;
    {quat_w, quat_x, quat_y, quat_z} <= q;
    @(posedge clk);
    while (quat_stall) @(posedge clk);
    expected_mats.push_back(want);
    sent_count++;
  endtask

  task automatic check_matrix(mat_t got);
    mat_t want;
    if (expected_mats.size() == 0) begin
      $error("matrix word with nothing expected");
      mismatches++;
    end else begin
      want = expected_mats.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got[8-i] !== want[8-i]) begin
          $error("%s: expected %0d, got %0d", entry_names[i],
                 $signed(want[8-i]), $signed(got[8-i]));
          mismatches++;
        end
      end
      checked_count++;
    end
  endtask

  always @(posedge clk) begin
    mat_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
    if (!rst && quat_valid && quat_stall) input_stall_cycles++;
    if (!rst && mat_valid && !mat_stall) begin
      check_matrix({row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
                    row2_col0, row2_col1, row2_col2});
    end
  end

  initial begin
    wait (phase == 2);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    quat_t q;
    directed_rows = '{
      {ZERO, ZERO, ZERO, ZERO, 1'b1, IDENTITY},
      {ONE, ZERO, ZERO, ZERO, 1'b1, IDENTITY},
      {MAX_NEG, ZERO, ZERO, ZERO, 1'b1, IDENTITY},
      {MAX_POS, ZERO, ZERO, ZERO, 1'b1, IDENTITY},
      {16'h0001, ZERO, ZERO, ZERO, 1'b1, IDENTITY},
      {ZERO, ONE, ZERO, ZERO, 1'b1, AXIS_X},
      {ZERO, ZERO, MAX_NEG, ZERO, 1'b1, AXIS_Y},
      {ZERO, ZERO, ZERO, MAX_POS, 1'b1, AXIS_Z},
      {MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 1'b1, CYCLE},
      {16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1, CYCLE},
      {MAX_POS, MAX_POS, MAX_POS, MAX_POS, 1'b0, NO_MAT},
      {MAX_NEG, MAX_POS, MAX_NEG, MAX_POS, 1'b0, NO_MAT},
      {MAX_POS, MAX_NEG, ZERO, ZERO, 1'b0, NO_MAT},
      {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, NO_MAT},
      {16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0, NO_MAT},
      {16'sd11585, 16'sd11585, ZERO, ZERO, 1'b0, NO_MAT},
      {16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192, 1'b0, NO_MAT},
      {ZERO, 16'sd3, -16'sd4, ZERO, 1'b0, NO_MAT},
      {16'sd100, -16'sd200, 16'sd300, -16'sd400, 1'b0, NO_MAT},
      {16'hFFFF, ZERO, ZERO, 16'h0001, 1'b0, NO_MAT},
      {MAX_POS, 16'h0001, MAX_NEG, 16'hFFFE, 1'b0, NO_MAT}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_quat(directed_rows[i].q, directed_rows[i].typed ? directed_rows[i].m
                                                           : rotation_from_quat(directed_rows[i].q));
    end

    for (int p = 0; p < 3; p++) begin
      phase <= p;
      send_idle_pct <= (p == 0) ? 31 : (p == 1) ? 78 : 0;
      recv_idle_pct <= (p == 0) ? 78 : (p == 1) ? 31 : 0;
      repeat (RANDOM_PER_PHASE) begin
        q = random_quat();
        send_quat(q, rotation_from_quat(q));
      end
    end
    quat_valid <= 1'b0;

    while (expected_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d quaternions sent (%0d from the table), %0d matrices checked",
             sent_count, DIRECTED_ROWS, checked_count);
    $display("input held off %0d cycles under backpressure, %0d mismatches",
             input_stall_cycles, mismatches);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
